/* rtl/core/padt_pkg.sv */
// ----------------------------------------------------------------------------
// padt_pkg: shared types and constants of the phase-angle dimmer timing unit
// Opcodes, result codes, register indexes, reset values and stage records.
// ----------------------------------------------------------------------------
package padt_pkg;

  localparam int unsigned DataW = 16;

  typedef enum logic [1:0] {
    OP_CROSS  = 2'd0,
    OP_SET    = 2'd1,
    OP_OFFSET = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_GLITCH = 2'd0,
    ST_OFF    = 2'd1,
    ST_FIRE   = 2'd2,
    ST_TARGET = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_MIN_PERIOD  = 2'd0,
    CFG_OFF_MARGIN  = 2'd1,
    CFG_PULSE_WIDTH = 2'd2,
    CFG_MIN_LEVEL   = 2'd3
  } cfg_idx_t;

  localparam logic [DataW-1:0] MinPeriodRst  = 16'd1875;
  localparam logic [DataW-1:0] OffMarginRst  = 16'd62;
  localparam logic [DataW-1:0] PulseWidthRst = 16'd12;
  localparam logic [DataW-1:0] MinLevelRst   = 16'd1500;
  localparam logic [DataW-1:0] LevelRst      = 16'hFFFF;
  localparam logic [DataW-1:0] TargetRst     = 16'hFFFF;
  localparam logic [DataW-1:0] SlewRst       = 16'hFFFF;
  localparam logic [DataW-1:0] EdgeRst       = 16'd0;
  localparam logic [DataW-1:0] FullScale     = 16'hFFFF;
  localparam int unsigned      DelayShift    = 17;

  typedef struct packed {
    logic [DataW-1:0] min_period;
    logic [DataW-1:0] off_margin;
    logic [DataW-1:0] pulse_width;
    logic [DataW-1:0] min_level;
  } cfg_t;

  typedef struct packed {
    logic               is_cross;
    status_t            status;
    logic [2*DataW-1:0] product;
    logic [DataW-2:0]   half;
    logic [DataW-1:0]   edge_ts;
    logic [DataW-1:0]   level;
    logic [DataW-1:0]   target;
  } mid_t;

  function automatic logic [DataW-1:0] max16(input logic [DataW-1:0] a,
                                             input logic [DataW-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

/* rtl/core/padt_in_if.sv */
// ----------------------------------------------------------------------------
// padt_in_if: request channel of the dimmer timing unit
// Valid/ready handshake with opcode, timestamp and target fields.
// ----------------------------------------------------------------------------
interface padt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [15:0]        timestamp;
  logic [15:0]        target_value;
  logic signed [15:0] offset_value;
  logic [15:0]        fade_step;

  modport source (
    output valid, opcode, timestamp, target_value, offset_value, fade_step,
    input  ready
  );
  modport sink (
    input  valid, opcode, timestamp, target_value, offset_value, fade_step,
    output ready
  );
endinterface

/* rtl/core/padt_out_if.sv */
// ----------------------------------------------------------------------------
// padt_out_if: result channel of the dimmer timing unit
// Valid/ready handshake with status, pulse times, level and target.
// ----------------------------------------------------------------------------
interface padt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] first_on;
  logic [15:0] first_off;
  logic [15:0] second_on;
  logic [15:0] second_off;
  logic [15:0] level_now;
  logic [15:0] target_now;

  modport source (
    output valid, status, first_on, first_off, second_on, second_off,
           level_now, target_now,
    input  ready
  );
  modport sink (
    input  valid, status, first_on, first_off, second_on, second_off,
           level_now, target_now,
    output ready
  );
endinterface

/* rtl/core/padt_step.sv */
// ----------------------------------------------------------------------------
// padt_step: request register, dimmer state and level/target update
// Checks the crossing period, slews the level, updates the target and
// forms the level * period product for the scheduling stage.
// ----------------------------------------------------------------------------
module padt_step (
  input  logic           clk,
  input  logic           rst_n,
  padt_in_if.sink        in_ch,
  input  padt_pkg::cfg_t cfg,
  output logic           mid_valid,
  input  logic           mid_ready,
  output padt_pkg::mid_t mid
);
  import padt_pkg::*;

  logic                    s1_valid_r;
  opcode_t                 op_r;
  logic [DataW-1:0]        ts_r;
  logic [DataW-1:0]        tv_r;
  logic signed [DataW-1:0] ov_r;
  logic [DataW-1:0]        fs_r;

  logic [DataW-1:0] level_r, level_nxt;
  logic [DataW-1:0] target_r, target_nxt;
  logic [DataW-1:0] slew_r, slew_nxt;
  logic [DataW-1:0] last_edge_r, last_edge_nxt;

  logic [DataW-1:0]        period;
  logic                    pass;
  logic [DataW-1:0]        slewed;
  logic signed [DataW+1:0] sum;
  logic                    is_cross;
  status_t                 status;

  assign in_ch.ready = !s1_valid_r || mid_ready;
  assign mid_valid   = s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r <= opcode_t'(in_ch.opcode);
      ts_r <= in_ch.timestamp;
      tv_r <= in_ch.target_value;
      ov_r <= in_ch.offset_value;
      fs_r <= in_ch.fade_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= LevelRst;
      target_r    <= TargetRst;
      slew_r      <= SlewRst;
      last_edge_r <= EdgeRst;
    end else if (s1_valid_r && mid_ready) begin
      level_r     <= level_nxt;
      target_r    <= target_nxt;
      slew_r      <= slew_nxt;
      last_edge_r <= last_edge_nxt;
    end
  end

  assign period = ts_r - last_edge_r;
  assign pass   = (period >= cfg.min_period);
  assign sum    = $signed({2'b00, target_r}) + $signed({{2{ov_r[DataW-1]}}, ov_r});

  // move level toward target by at most the slew step
  always_comb begin
    slewed = level_r;
    if (level_r < target_r) begin
      if ((target_r - level_r) < slew_r) begin
        slewed = target_r;
      end else begin
        slewed = level_r + slew_r;
      end
    end else if (level_r > target_r) begin
      if ((level_r - target_r) < slew_r) begin
        slewed = target_r;
      end else begin
        slewed = level_r - slew_r;
      end
    end
  end

  always_comb begin
    level_nxt     = level_r;
    target_nxt    = target_r;
    slew_nxt      = slew_r;
    last_edge_nxt = last_edge_r;
    is_cross      = 1'b0;
    status        = ST_GLITCH;
    unique case (op_r)
      OP_CROSS: begin
        if (pass) begin
          last_edge_nxt = ts_r;
          level_nxt     = slewed;
          is_cross      = 1'b1;
        end
      end
      OP_SET: begin
        target_nxt = max16(tv_r, cfg.min_level);
        slew_nxt   = fs_r;
        status     = ST_TARGET;
      end
      OP_OFFSET: begin
        priority if (sum[DataW+1]) begin
          target_nxt = cfg.min_level;
        end else if (sum[DataW]) begin
          target_nxt = FullScale;
        end else begin
          target_nxt = max16(sum[DataW-1:0], cfg.min_level);
        end
        slew_nxt = fs_r;
        status   = ST_TARGET;
      end
      OP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mid.is_cross = is_cross;
    mid.status   = status;
    mid.product  = level_nxt * period;
    mid.half     = period[DataW-1:1];
    mid.edge_ts  = ts_r;
    mid.level    = level_nxt;
    mid.target   = target_nxt;
  end

endmodule

/* rtl/core/padt_sched.sv */
// ----------------------------------------------------------------------------
// padt_sched: firing delay, off decision and gate pulse times
// Registers the product, derives the delay and the four wrapped pulse
// times, and holds the result in the output register.
// ----------------------------------------------------------------------------
module padt_sched (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           mid_valid,
  output logic           mid_ready,
  input  padt_pkg::mid_t mid,
  input  padt_pkg::cfg_t cfg,
  padt_out_if.source     out_ch
);
  import padt_pkg::*;

  logic             s2_valid_r;
  mid_t             mid_r;
  logic             out_valid_r;
  status_t          status_r;
  logic [DataW-1:0] t0_r, t1_r, t2_r, t3_r;
  logic [DataW-1:0] level_r, target_r;

  logic             out_load;
  logic [DataW-2:0] delay;
  logic [DataW-2:0] left;
  status_t          status_nxt;
  logic [DataW-1:0] t0_nxt, t1_nxt, t2_nxt, t3_nxt;
  logic [DataW-1:0] a0, a2;

  assign out_load  = !out_valid_r || out_ch.ready;
  assign mid_ready = !s2_valid_r || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (mid_ready) begin
      s2_valid_r <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_valid && mid_ready) begin
      mid_r <= mid;
    end
  end

  assign delay = mid_r.product[2*DataW-1:DelayShift];
  assign left  = mid_r.half - delay;
  assign a0    = mid_r.edge_ts + {1'b0, delay};
  assign a2    = a0 + {1'b0, mid_r.half};

  always_comb begin
    status_nxt = mid_r.status;
    t0_nxt     = '0;
    t1_nxt     = '0;
    t2_nxt     = '0;
    t3_nxt     = '0;
    if (mid_r.is_cross) begin
      if ({1'b0, left} < cfg.off_margin) begin
        status_nxt = ST_OFF;
      end else begin
        status_nxt = ST_FIRE;
        t0_nxt     = a0;
        t1_nxt     = a0 + cfg.pulse_width;
        t2_nxt     = a2;
        t3_nxt     = a2 + cfg.pulse_width;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r && out_load) begin
      status_r <= status_nxt;
      t0_r     <= t0_nxt;
      t1_r     <= t1_nxt;
      t2_r     <= t2_nxt;
      t3_r     <= t3_nxt;
      level_r  <= mid_r.level;
      target_r <= mid_r.target;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.first_on   = t0_r;
  assign out_ch.first_off  = t1_r;
  assign out_ch.second_on  = t2_r;
  assign out_ch.second_off = t3_r;
  assign out_ch.level_now  = level_r;
  assign out_ch.target_now = target_r;

endmodule

/* rtl/core/phase_angle_dimmer_timing_unit.sv */
// ----------------------------------------------------------------------------
// phase_angle_dimmer_timing_unit: triac gate pulse timing
// A result is valid once its request has passed the request register, the
// product register and the result register.
// Throughput: one request per cycle unless the result side stalls; the 16x16
// level * period multiply sits between the request and product registers.
// Reset: synchronous active-low; level, target and slew step go to 65535,
// last edge to 0, registers to their defaults, no result pending.
// ----------------------------------------------------------------------------
module phase_angle_dimmer_timing_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  padt_in_if.sink                 in_ch,
  padt_out_if.source              out_ch,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [padt_pkg::DataW-1:0] cfg_wdata
);
  import padt_pkg::*;

  cfg_t cfg_r;
  logic mid_valid;
  logic mid_ready;
  mid_t mid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_period  <= MinPeriodRst;
      cfg_r.off_margin  <= OffMarginRst;
      cfg_r.pulse_width <= PulseWidthRst;
      cfg_r.min_level   <= MinLevelRst;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MIN_PERIOD:  cfg_r.min_period  <= cfg_wdata;
        CFG_OFF_MARGIN:  cfg_r.off_margin  <= cfg_wdata;
        CFG_PULSE_WIDTH: cfg_r.pulse_width <= cfg_wdata;
        CFG_MIN_LEVEL:   cfg_r.min_level   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  padt_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg_r),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid       (mid)
  );

  padt_sched u_sched (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid       (mid),
    .cfg       (cfg_r),
    .out_ch    (out_ch)
  );

endmodule

/* rtl/core/padt_check.sv */
// ----------------------------------------------------------------------------
// padt_check: port-level checks of the dimmer timing unit
// Watches the result channel and reset; bound to the top level.
// ----------------------------------------------------------------------------
module padt_check (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [15:0] out_first_on,
  input logic [15:0] out_first_off,
  input logic [15:0] out_second_on,
  input logic [15:0] out_second_off
);
  import padt_pkg::*;

  // held result stays valid and keeps its status, first-on and second-off times
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_first_on) && $stable(out_second_off))
    else $error("result changed while stalled");

  a_idle_times: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_FIRE |->
      out_first_on == 16'd0 && out_first_off == 16'd0
      && out_second_on == 16'd0 && out_second_off == 16'd0)
    else $error("pulse times set without firing");

  a_same_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FIRE |->
      16'(out_first_off - out_first_on) == 16'(out_second_off - out_second_on))
    else $error("gate pulses differ in width");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind phase_angle_dimmer_timing_unit padt_check u_check (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_first_on   (out_ch.first_on),
  .out_first_off  (out_ch.first_off),
  .out_second_on  (out_ch.second_on),
  .out_second_off (out_ch.second_off)
);

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for the phase-angle dimmer timing unit
// Drives crossing captures and target requests through the valid/ready
// channels, predicts every gate timing result in a scoreboard, and compares
// each result field by field. Runs through several register settings,
// with random idling on both sides and a long stall on the result side.
// ----------------------------------------------------------------------------
module tb;
  import padt_pkg::*;

  localparam int unsigned WatchdogLimit  = 4000;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned MaxReports     = 10;
  localparam int unsigned ProductShift   = 17;

  typedef struct {
    opcode_t            op;
    logic [15:0]        ts;
    logic [15:0]        tval;
    logic signed [15:0] offs;
    logic [15:0]        fstep;
  } dim_req_t;

  typedef struct {
    status_t     status;
    logic [15:0] first_on;
    logic [15:0] first_off;
    logic [15:0] second_on;
    logic [15:0] second_off;
    logic [15:0] level_now;
    logic [15:0] target_now;
  } gate_res_t;

  class gate_timing_scoreboard;
    cfg_t        regs;
    logic [15:0] level;
    logic [15:0] target;
    logic [15:0] slew;
    logic [15:0] last_edge;
    gate_res_t   gate_results_due[$];
    int unsigned faults;

    function new();
      regs = '{min_period: 16'd1875, off_margin: 16'd62, pulse_width: 16'd12,
               min_level: 16'd1500};
      level     = 16'hFFFF;
      target    = 16'hFFFF;
      slew      = 16'hFFFF;
      last_edge = 16'h0000;
      faults    = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [15:0] value);
      case (idx)
        CFG_MIN_PERIOD:  regs.min_period  = value;
        CFG_OFF_MARGIN:  regs.off_margin  = value;
        CFG_PULSE_WIDTH: regs.pulse_width = value;
        CFG_MIN_LEVEL:   regs.min_level   = value;
      endcase
    endfunction

    function void note_request(dim_req_t r);
      gate_res_t   e;
      logic [15:0] period;
      logic [15:0] half;
      logic [31:0] delay;
      int          sum;
      e = '{ST_GLITCH, '0, '0, '0, '0, '0, '0};
      case (r.op)
        OP_CROSS: begin
          period = r.ts - last_edge;
          if (period >= regs.min_period) begin
            last_edge = r.ts;
            if (level < target)
              level = (target - level < slew) ? target : level + slew;
            if (level > target)
              level = (level - target < slew) ? target : level - slew;
            delay = (32'(level) * 32'(period)) >> ProductShift;
            half  = period >> 1;
            if (32'(half) - delay < 32'(regs.off_margin)) begin
              e.status = ST_OFF;
            end else begin
              e.status     = ST_FIRE;
              e.first_on   = last_edge + delay[15:0];
              e.first_off  = e.first_on + regs.pulse_width;
              e.second_on  = e.first_on + half;
              e.second_off = e.second_on + regs.pulse_width;
            end
          end
        end
        OP_SET: begin
          target   = (r.tval > regs.min_level) ? r.tval : regs.min_level;
          slew     = r.fstep;
          e.status = ST_TARGET;
        end
        OP_OFFSET: begin
          sum = int'(target) + int'(r.offs);
          if (sum > 65535)
            target = 16'hFFFF;
          else if (sum < 0)
            target = regs.min_level;
          else
            target = (sum[15:0] > regs.min_level) ? sum[15:0] : regs.min_level;
          slew     = r.fstep;
          e.status = ST_TARGET;
        end
        default: ;
      endcase
      e.level_now  = level;
      e.target_now = target;
      gate_results_due.push_back(e);
    endfunction

    function string show(gate_res_t r);
      return $sformatf("st=%0d on1=%h off1=%h on2=%h off2=%h lvl=%h tgt=%h",
                       r.status, r.first_on, r.first_off, r.second_on,
                       r.second_off, r.level_now, r.target_now);
    endfunction

    function void check_result(gate_res_t got);
      gate_res_t e;
      if (gate_results_due.size() == 0) begin
        faults++;
        if (faults <= MaxReports) $display("unexpected result: %s", show(got));
        return;
      end
      e = gate_results_due.pop_front();
      if (got.status !== e.status || got.first_on !== e.first_on ||
          got.first_off !== e.first_off || got.second_on !== e.second_on ||
          got.second_off !== e.second_off || got.level_now !== e.level_now ||
          got.target_now !== e.target_now) begin
        faults++;
        if (faults <= MaxReports) begin
          $display("result mismatch");
          $display("  expected %s", show(e));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  padt_in_if  in_ch();
  padt_out_if out_ch();

  phase_angle_dimmer_timing_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  gate_timing_scoreboard sb = new();

  logic [15:0] gen_edge     = 16'h0000;
  bit          src_idle     = 1'b1;
  bit          sink_idle    = 1'b1;
  bit          long_hold    = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned sent_items   = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin : monitor
    dim_req_t  req;
    gate_res_t res;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      req = '{opcode_t'(in_ch.opcode), in_ch.timestamp, in_ch.target_value,
              in_ch.offset_value, in_ch.fade_step};
      sb.note_request(req);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      res = '{status_t'(out_ch.status), out_ch.first_on, out_ch.first_off,
              out_ch.second_on, out_ch.second_off, out_ch.level_now,
              out_ch.target_now};
      sb.check_result(res);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) ||
        (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on demand
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk);
        long_hold = 1'b0;
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  function automatic dim_req_t rand_req(opcode_t op);
    dim_req_t r;
    r.op    = op;
    r.ts    = 16'($urandom);
    r.tval  = 16'($urandom);
    r.offs  = 16'($urandom);
    r.fstep = 16'($urandom);
    return r;
  endfunction

  function automatic logic [15:0] pick_step();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k == 0) return 16'h0000;
    if (k < 5) return 16'($urandom_range(1, 2000));
    return 16'($urandom);
  endfunction

  task automatic send_req(dim_req_t r);
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= r.op;
    in_ch.timestamp    <= r.ts;
    in_ch.target_value <= r.tval;
    in_ch.offset_value <= r.offs;
    in_ch.fade_step    <= r.fstep;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    // track the last accepted crossing so random periods stay meaningful
    if (r.op == OP_CROSS && 16'(r.ts - gen_edge) >= sb.regs.min_period)
      gen_edge = r.ts;
    sent_items++;
    if (src_idle && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic cross_at(logic [15:0] ts);
    dim_req_t r = rand_req(OP_CROSS);
    r.ts = ts;
    send_req(r);
  endtask

  task automatic set_tgt(logic [15:0] v, logic [15:0] step);
    dim_req_t r = rand_req(OP_SET);
    r.tval  = v;
    r.fstep = step;
    send_req(r);
  endtask

  task automatic offs_tgt(logic signed [15:0] o, logic [15:0] step);
    dim_req_t r = rand_req(OP_OFFSET);
    r.offs  = o;
    r.fstep = step;
    send_req(r);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.gate_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    sb.write_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic write_cfg(cfg_t c);
    write_reg(CFG_MIN_PERIOD, c.min_period);
    write_reg(CFG_OFF_MARGIN, c.off_margin);
    write_reg(CFG_PULSE_WIDTH, c.pulse_width);
    write_reg(CFG_MIN_LEVEL, c.min_level);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int unsigned n);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned delta;
    dim_req_t    r;
    stop_at = sent_items + n;
    while (sent_items < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        r    = rand_req(OP_CROSS);
        pick = $urandom_range(0, 99);
        if (pick < 80)
          delta = sb.regs.min_period + $urandom_range(0, 3000);
        else if (pick < 88)
          delta = (sb.regs.min_period == 0) ? 0 : $urandom_range(0, sb.regs.min_period - 1);
        else if (pick < 93)
          delta = sb.regs.min_period;
        else
          delta = $urandom_range(0, 65535);
        if (delta > 65535) delta = 65535;
        r.ts = gen_edge + 16'(delta);
      end else if (pick < 72) begin
        r = rand_req(OP_SET);
        case ($urandom_range(0, 4))
          0, 1:    r.tval = 16'($urandom_range(0, 30000));
          2:       r.tval = 16'($urandom_range(0, 3000));
          default: r.tval = 16'($urandom);
        endcase
        r.fstep = pick_step();
      end else if (pick < 92) begin
        r = rand_req(OP_OFFSET);
        if ($urandom_range(0, 1)) r.offs = 16'($urandom_range(0, 6000) - 3000);
        r.fstep = pick_step();
      end else begin
        r = rand_req(OP_NONE);
      end
      send_req(r);
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_MIN_PERIOD;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.opcode       <= OP_CROSS;
    in_ch.timestamp    <= '0;
    in_ch.target_value <= '0;
    in_ch.offset_value <= '0;
    in_ch.fade_step    <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed requests on the reset register values
    cross_at(16'd0);
    send_req('{OP_NONE, 16'h0000, 16'h0000, 16'sh0000, 16'h0000});
    send_req('{OP_NONE, 16'hFFFF, 16'hFFFF, 16'shFFFF, 16'hFFFF});
    set_tgt(16'h0000, 16'h0000);
    cross_at(16'd2500);
    set_tgt(16'hFFFF, 16'hFFFF);
    offs_tgt(16'sh7FFF, 16'hFFFF);
    set_tgt(16'd2000, 16'hFFFF);
    cross_at(gen_edge + 16'd2500);
    offs_tgt(16'sh8000, 16'd500);
    offs_tgt(16'sd100, 16'd500);
    offs_tgt(-16'sd200, 16'd500);
    set_tgt(16'd40000, 16'd1000);
    cross_at(gen_edge + 16'd1874);
    cross_at(gen_edge + 16'd1875);
    cross_at(gen_edge + 16'hFFFF);
    set_tgt(16'd1500, 16'd300);
    cross_at(gen_edge + 16'd2500);
    set_tgt(16'd1400, 16'hFFFF);
    cross_at(gen_edge + 16'd2500);
    cross_at(gen_edge + 16'd3000);
    run_random(400);

    drain();
    write_cfg('{min_period: 16'h0000, off_margin: 16'h0000, pulse_width: 16'h0000,
                min_level: 16'h0000});
    run_random(120);
    drain();
    run_random(130);

    drain();
    write_cfg('{min_period: 16'hFFFF, off_margin: 16'hFFFF, pulse_width: 16'hFFFF,
                min_level: 16'hFFFF});
    run_random(120);

    drain();
    write_cfg('{min_period: 16'd1875, off_margin: 16'd62, pulse_width: 16'd12,
                min_level: 16'd1500});
    run_random(50);
    long_hold = 1'b1;
    run_random(250);

    drain();
    write_cfg('{min_period: 16'($urandom_range(500, 4000)),
                off_margin: 16'($urandom_range(0, 600)),
                pulse_width: 16'($urandom_range(0, 400)),
                min_level: 16'($urandom_range(0, 30000))});
    run_random(300);

    drain();
    write_cfg('{min_period: 16'd1, off_margin: 16'd1, pulse_width: 16'hFFFF,
                min_level: 16'd1500});
    run_random(250);

    // closing stretch with both sides running flat out
    drain();
    write_cfg('{min_period: 16'($urandom_range(1200, 2600)),
                off_margin: 16'($urandom_range(0, 300)),
                pulse_width: 16'($urandom_range(1, 200)),
                min_level: 16'($urandom_range(0, 8000))});
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    run_random(330);

    drain();
    repeat (4) @(posedge clk);
    if (sb.faults == 0 && sb.gate_results_due.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
